// ----- hw/rtl/hmbp_pkg.sv -----
// Package for the HTTP message byte parser.
// Holds the parse phase type, role codes, byte constants and the header name table.
// Used by the result interface and the top level; depends on nothing.
package hmbp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int ROLE_BITS = 3;
  localparam int NAME_LEN = 14;
  localparam int NAME_POS_BITS = 4;

  localparam logic [ROLE_BITS-1:0] ROLE_NONE  = 3'd0;
  localparam logic [ROLE_BITS-1:0] ROLE_LINE  = 3'd1;
  localparam logic [ROLE_BITS-1:0] ROLE_NAME  = 3'd2;
  localparam logic [ROLE_BITS-1:0] ROLE_VALUE = 3'd3;
  localparam logic [ROLE_BITS-1:0] ROLE_BODY  = 3'd4;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [3:0] DECIMAL_BASE = 4'd10;

  typedef enum logic [4:0] {
    PH_INIT  = 5'b00001,
    PH_LINE  = 5'b00010,
    PH_NAME  = 5'b00100,
    PH_VALUE = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_t;

  // Characters of the header name "Content-Length", in order.
  function automatic logic [7:0] length_name_char(input logic [NAME_POS_BITS-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/hmbp_if.sv -----
// Stream interfaces of the HTTP message byte parser: input events and classified results.
// Each carries valid, ready and its payload. Depends on hmbp_pkg.

interface hmbp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface hmbp_out_if
  import hmbp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ROLE_BITS-1:0] role;
  logic [7:0]           byte_out;
  logic                 token_end;
  logic                 length_header_done;
  logic                 length_error;
  logic                 message_end;
  logic                 close_error;

  modport source (
    output valid, role, byte_out, token_end, length_header_done, length_error,
           message_end, close_error,
    input  ready
  );
  modport sink (
    input  valid, role, byte_out, token_end, length_header_done, length_error,
           message_end, close_error,
    output ready
  );
endinterface

// ----- hw/rtl/http_message_byte_parser.sv -----
// HTTP/1.1 message byte parser with Content-Length framing; top level.
// Each accepted transfer's result is registered in the output register.
// Throughput: one transfer per cycle; input ready is high whenever the output register
// is empty or is being drained in the same cycle.
// Reset (rst, synchronous): parser goes to its initial phase, counters clear, output empties.
// Depends on hmbp_pkg and hmbp_if.
module http_message_byte_parser
  import hmbp_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  hmbp_in_if.sink       byte_in,
  hmbp_out_if.source    result
);

  localparam int WIDE_BITS = LENGTH_BITS + 4;

  phase_t                   phase, phase_next;
  logic [NAME_POS_BITS-1:0] name_pos, name_pos_next;
  logic                     name_mismatch, name_mismatch_next;
  logic                     header_is_length, header_is_length_next;
  logic [LENGTH_BITS-1:0]   value_accum, value_accum_next;
  logic                     value_valid, value_valid_next;
  logic                     value_stopped, value_stopped_next;
  logic                     value_sat, value_sat_next;
  logic [LENGTH_BITS-1:0]   body_remaining, body_remaining_next;

  logic [ROLE_BITS-1:0] role_c;
  logic [7:0]           byte_c;
  logic                 te_c, done_c, lerr_c, mend_c, cerr_c;

  logic                 accept;
  logic [7:0]           b;
  logic                 is_digit;
  logic [WIDE_BITS-1:0] accum_wide, digit_wide, accum_times_ten;
  logic                 accum_overflow;
  phase_t               work_phase;
  logic                 restart;

  assign byte_in.ready = !result.valid || result.ready;
  assign accept = byte_in.valid && byte_in.ready;
  assign b = byte_in.data_byte;

  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign accum_wide = {4'b0, value_accum};
  assign digit_wide = WIDE_BITS'(b - CHAR_ZERO);
  assign accum_times_ten = (accum_wide << 3) + (accum_wide << 1) + digit_wide;
  assign accum_overflow = |accum_times_ten[WIDE_BITS-1:LENGTH_BITS];

  always_comb begin
    priority if (phase == PH_NAME || phase == PH_VALUE || phase == PH_BODY) begin
      work_phase = phase;
    end else begin
      work_phase = PH_LINE;
    end
  end

  always_comb begin
    phase_next             = phase;
    name_pos_next          = name_pos;
    name_mismatch_next     = name_mismatch;
    header_is_length_next  = header_is_length;
    value_accum_next       = value_accum;
    value_valid_next       = value_valid;
    value_stopped_next     = value_stopped;
    value_sat_next         = value_sat;
    body_remaining_next    = body_remaining;
    role_c  = ROLE_NONE;
    byte_c  = b;
    te_c    = 1'b0;
    done_c  = 1'b0;
    lerr_c  = 1'b0;
    mend_c  = 1'b0;
    cerr_c  = 1'b0;
    restart = 1'b0;

    if (byte_in.kind == KIND_CLOSE) begin
      byte_c  = 8'h00;
      restart = 1'b1;
      if (phase == PH_BODY) begin
        mend_c = 1'b1;
      end else if (phase == PH_LINE || phase == PH_NAME || phase == PH_VALUE) begin
        cerr_c = 1'b1;
      end
    end else begin
      phase_next = work_phase;
      unique case (work_phase)
        PH_NAME: begin
          if (b == CHAR_SP) begin
            te_c = 1'b1;
            header_is_length_next = !name_mismatch &&
                                    (name_pos == NAME_POS_BITS'(NAME_LEN));
            name_pos_next      = '0;
            name_mismatch_next = 1'b0;
            value_accum_next   = '0;
            value_valid_next   = 1'b0;
            value_stopped_next = 1'b0;
            value_sat_next     = 1'b0;
            phase_next         = PH_VALUE;
          end else if (b == CHAR_LF) begin
            phase_next = PH_BODY;
          end else if (b == CHAR_CR || b == CHAR_COLON) begin
            role_c = ROLE_NONE;
          end else begin
            role_c = ROLE_NAME;
            if (name_pos < NAME_POS_BITS'(NAME_LEN) && b == length_name_char(name_pos)) begin
              name_pos_next = name_pos + 1'b1;
            end else begin
              name_mismatch_next = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (b == CHAR_CR) begin
            te_c = 1'b1;
            if (header_is_length) begin
              if (!value_valid) begin
                lerr_c = 1'b1;
              end else begin
                body_remaining_next = value_accum;
                done_c = 1'b1;
                lerr_c = value_sat;
              end
            end
            value_accum_next   = '0;
            value_valid_next   = 1'b0;
            value_stopped_next = 1'b0;
            value_sat_next     = 1'b0;
          end else if (b == CHAR_LF) begin
            phase_next         = PH_NAME;
            name_pos_next      = '0;
            name_mismatch_next = 1'b0;
          end else begin
            role_c = ROLE_VALUE;
            if (!value_stopped) begin
              if (is_digit) begin
                if (!value_sat) begin
                  if (accum_overflow) begin
                    value_accum_next = '1;
                    value_sat_next   = 1'b1;
                  end else begin
                    value_accum_next = accum_times_ten[LENGTH_BITS-1:0];
                  end
                end
                value_valid_next = 1'b1;
              end else begin
                value_stopped_next = 1'b1;
              end
            end
          end
        end
        PH_BODY: begin
          role_c = ROLE_BODY;
          if (body_remaining != '0) begin
            body_remaining_next = body_remaining - 1'b1;
          end
        end
        default: begin
          if (b == CHAR_LF) begin
            phase_next         = PH_NAME;
            name_pos_next      = '0;
            name_mismatch_next = 1'b0;
          end else if (b == CHAR_CR || b == CHAR_SP) begin
            te_c = 1'b1;
          end else begin
            role_c = ROLE_LINE;
          end
        end
      endcase
      if (phase_next == PH_BODY && body_remaining_next == '0) begin
        mend_c  = 1'b1;
        restart = 1'b1;
      end
    end

    if (restart) begin
      phase_next            = PH_INIT;
      name_pos_next         = '0;
      name_mismatch_next    = 1'b0;
      header_is_length_next = 1'b0;
      value_accum_next      = '0;
      value_valid_next      = 1'b0;
      value_stopped_next    = 1'b0;
      value_sat_next        = 1'b0;
      body_remaining_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_INIT;
      name_pos         <= '0;
      name_mismatch    <= 1'b0;
      header_is_length <= 1'b0;
      value_accum      <= '0;
      value_valid      <= 1'b0;
      value_stopped    <= 1'b0;
      value_sat        <= 1'b0;
      body_remaining   <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      name_pos         <= name_pos_next;
      name_mismatch    <= name_mismatch_next;
      header_is_length <= header_is_length_next;
      value_accum      <= value_accum_next;
      value_valid      <= value_valid_next;
      value_stopped    <= value_stopped_next;
      value_sat        <= value_sat_next;
      body_remaining   <= body_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (byte_in.ready) begin
      result.valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.role               <= role_c;
      result.byte_out           <= byte_c;
      result.token_end          <= te_c;
      result.length_header_done <= done_c;
      result.length_error       <= lerr_c;
      result.message_end        <= mend_c;
      result.close_error        <= cerr_c;
    end
  end

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> body_remaining != '0)
    else $error("Parser is in the body with no bytes remaining.");

  a_close_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in.kind == KIND_CLOSE |=> phase == PH_INIT)
    else $error("Close transfer did not return the parser to its initial phase.");

  a_end_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.message_end && result.close_error))
    else $error("Result reports both message end and close error.");

  a_length_done_at_token_end: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.length_header_done |-> result.token_end &&
                                                 result.role == ROLE_NONE)
    else $error("Length applied away from the end of a header value.");

endmodule
